[rtl/core/htl_pkg.sv]
// package for the tree lock unit: field widths, mode codes, control structs
`default_nettype none

package htl_pkg;

	// fixed field widths
	localparam int MODE_W     = 2;
	localparam int NODE_W     = 5;
	localparam int COUNT_W    = 5;

	// default number of tree levels
	localparam int TREE_DEPTH_DEF = 5;

	// request modes
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOCK   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UNLOCK = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;     // take a request from the ports
		logic capture;  // read the named node's entry
		logic check;    // read one ancestor's lock bit
		logic set;      // write the named node's lock bit
		logic adjust;   // update one ancestor's count
		logic finish;   // register the result
	} htl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic in_valid;     // node on the input port is in the tree
		logic parent_zero;  // current address has no parent
		logic upd;          // request passes and changes the tree
		logic node_root;    // named node is the root
	} htl_stat_t;

endpackage

`default_nettype wire

[rtl/core/htl_dpath.sv]
// datapath of the tree lock unit: node storage, ancestor walk, result registers
`default_nettype none

module htl_dpath #(
	parameter int TREE_DEPTH = htl_pkg::TREE_DEPTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire [htl_pkg::MODE_W-1:0]    mode,
	input  wire [htl_pkg::NODE_W-1:0]    node_index,
	input  htl_pkg::htl_cmd_t            cmd,
	output htl_pkg::htl_stat_t           stat,
	output logic                         success,
	output logic                         node_locked,
	output logic                         done
);
	import htl_pkg::*;

	// reachable nodes are limited by the node field width
	localparam int FullNum = (1 << TREE_DEPTH) - 1;
	localparam int MaxNum  = (1 << NODE_W) - 1;
	localparam int NodeNum = (FullNum > MaxNum) ? MaxNum : FullNum;
	localparam int NodeCnt = NodeNum + 1;
	localparam int AW      = $clog2(NodeCnt);
	localparam logic [NODE_W-1:0] NodeMax = NODE_W'(NodeNum);

	logic               lock_q [NodeCnt];
	logic [COUNT_W-1:0] cnt_q  [NodeCnt];

	logic [AW-1:0]     addr_q;
	logic [AW-1:0]     node_q;
	logic [MODE_W-1:0] mode_q;
	logic              valid_q;
	logic              node_lock_q;
	logic              node_free_q;
	logic              anc_lock_q;
	logic              done_q;
	logic              success_q;
	logic              locked_q;

	logic               rd_lock;
	logic [COUNT_W-1:0] rd_cnt;
	logic               free_path;
	logic               upd;
	logic               succ;

	// single read port at the walk address
	assign rd_lock = lock_q[addr_q];
	assign rd_cnt  = cnt_q[addr_q];

	// pass/fail decision
	always_comb begin
		free_path = node_free_q && !anc_lock_q;
		upd = free_path && (((mode_q == MODE_LOCK) && !node_lock_q) ||
			((mode_q == MODE_UNLOCK) && node_lock_q));
		succ = upd || (mode_q == MODE_QUERY);
	end

	// status to the controller
	always_comb begin
		stat.in_valid    = (node_index != '0) && (node_index <= NodeMax);
		stat.parent_zero = (addr_q >> 1) == '0;
		stat.upd         = upd;
		stat.node_root   = node_q == AW'(1);
	end

	// request registers and ancestor walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			node_q  <= node_index[AW-1:0];
			addr_q  <= node_index[AW-1:0];
			mode_q  <= mode;
			valid_q <= stat.in_valid;
		end
		if (cmd.capture) begin
			node_lock_q <= rd_lock;
			node_free_q <= rd_cnt == '0;
			anc_lock_q  <= 1'b0;
			addr_q      <= addr_q >> 1;
		end
		if (cmd.check) begin
			anc_lock_q <= anc_lock_q | rd_lock;
			addr_q     <= addr_q >> 1;
		end
		if (cmd.set) begin
			addr_q <= node_q >> 1;
		end
		if (cmd.adjust) begin
			addr_q <= addr_q >> 1;
		end
		if (cmd.finish) begin
			success_q <= valid_q && succ;
			locked_q  <= valid_q && (node_lock_q ^ upd);
		end
	end

	// node storage: lock bits and locked-descendant counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NodeCnt; i++) begin
				lock_q[i] <= 1'b0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (cmd.set && upd) begin
				lock_q[node_q] <= mode_q == MODE_LOCK;
			end
			if (cmd.adjust) begin
				if (mode_q == MODE_LOCK) begin
					cnt_q[addr_q] <= rd_cnt + COUNT_W'(1);
				end else if (rd_cnt != '0) begin
					cnt_q[addr_q] <= rd_cnt - COUNT_W'(1);
				end
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign success     = success_q;
	assign node_locked = locked_q;
	assign done        = done_q;

endmodule

`default_nettype wire

[rtl/core/htl_ctrl.sv]
// controller of the tree lock unit: sequences check and update walks
`default_nettype none

module htl_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  htl_pkg::htl_stat_t  stat,
	output htl_pkg::htl_cmd_t   cmd,
	output logic                busy
);
	import htl_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_SET   = 3'd3;
	localparam logic [2:0] S_ADJ   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = stat.in_valid ? S_READ : S_FIN;
				end
			end
			S_READ: begin
				cmd.capture = 1'b1;
				state_d     = stat.parent_zero ? S_SET : S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (stat.parent_zero) begin
					state_d = S_SET;
				end
			end
			S_SET: begin
				cmd.set = 1'b1;
				state_d = (stat.upd && !stat.node_root) ? S_ADJ : S_FIN;
			end
			S_ADJ: begin
				cmd.adjust = 1'b1;
				if (stat.parent_zero) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

`default_nettype wire

[rtl/core/hierarchical_tree_lock_unit.sv]
// top level of the tree lock unit: controller plus datapath
//
//  channel   signals                      transfer when
//  request   start, mode, node_index      start high and busy low
//  result    done, success, node_locked   done high (one cycle, no back-pressure)
//
// the unit reads the node's entry and checks each ancestor's lock bit; if a lock
// or unlock succeeds it writes the node's lock bit and updates each ancestor's
// count. the ancestor walk reads or writes one level per cycle through a single
// port on the node storage. an invalid node goes straight to the result. busy
// stays high until the result cycle, so a new request can be taken while a
// result is shown. reset clears all lock bits and counts at once.
`default_nettype none

module hierarchical_tree_lock_unit #(
	parameter int TREE_DEPTH = htl_pkg::TREE_DEPTH_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire [htl_pkg::MODE_W-1:0]  mode,
	input  wire [htl_pkg::NODE_W-1:0]  node_index,
	output logic                       done,
	output logic                       success,
	output logic                       node_locked
);
	import htl_pkg::*;

	htl_cmd_t  cmd;
	htl_stat_t stat;

	// sequencer
	htl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// storage and walk logic
	htl_dpath #(
		.TREE_DEPTH (TREE_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode),
		.node_index  (node_index),
		.cmd         (cmd),
		.stat        (stat),
		.success     (success),
		.node_locked (node_locked),
		.done        (done)
	);

endmodule

`default_nettype wire

[rtl/core/htl_checker.sv]
// port checker for the tree lock unit and its bind
`default_nettype none

module htl_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        start,
	input wire                        busy,
	input wire [htl_pkg::NODE_W-1:0]  node_index,
	input wire                        done,
	input wire                        success,
	input wire                        node_locked
);
	import htl_pkg::*;

	// an accepted request makes the unit busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after request transfer");

	// a result appears exactly when busy drops
	a_done_on_fall: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $fell(busy))
		else $error("result strobe without end of busy");

	a_fall_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy ended without a result");

	// node zero fails at once
	a_node_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (node_index == '0) |=> ##1 (done && !success && !node_locked))
		else $error("node zero request not rejected");

endmodule

bind hierarchical_tree_lock_unit htl_checker u_htl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.node_index  (node_index),
	.done        (done),
	.success     (success),
	.node_locked (node_locked)
);

`default_nettype wire
